/* design/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold on the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// expression must hold on every cycle out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

`endif

/* design/pcg_pkg.sv */
`default_nettype none

package pcg_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] LCG_MUL  = 32'd747796405;
    localparam logic [WORD_W-1:0] LCG_INC  = 32'd2891336453;
    localparam logic [WORD_W-1:0] PERM_MUL = 32'd277803737;
    localparam int SEL_SHIFT = 28;
    localparam int XS_SHIFT  = 22;
    localparam logic [4:0] SHIFT_BIAS = 5'd4;

    localparam logic [1:0] MODE_RAW     = 2'd0;
    localparam logic [1:0] MODE_BOUNDED = 2'd1;
    localparam logic [1:0] MODE_SIGNED  = 2'd2;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

endpackage

`default_nettype wire

/* design/pcg_mul_serial.sv */
`default_nettype none

// shift-add multiplier, low 32 bits of the product, one multiplier bit per cycle
module pcg_mul_serial (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pcg_pkg::WORD_W-1:0]  i_a,
    input  wire logic [pcg_pkg::WORD_W-1:0]  i_b,
    output pcg_pkg::t_unit_status            o_status,
    output logic      [pcg_pkg::WORD_W-1:0]  o_product
);

    localparam logic [pcg_pkg::CNT_W-1:0] CNT_LAST = pcg_pkg::CNT_W'(pcg_pkg::WORD_W - 1);

    logic [pcg_pkg::WORD_W-1:0] r_a, r_b, r_acc;
    logic [pcg_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[pcg_pkg::WORD_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[pcg_pkg::WORD_W-1:1]};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_product     = r_acc;

endmodule

`default_nettype wire

/* design/pcg_rem_serial.sv */
`default_nettype none

// restoring remainder, one dividend bit per cycle; divisor must be nonzero
module pcg_rem_serial (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pcg_pkg::WORD_W-1:0]  i_dividend,
    input  wire logic [pcg_pkg::WORD_W-1:0]  i_divisor,
    output pcg_pkg::t_unit_status            o_status,
    output logic      [pcg_pkg::WORD_W-1:0]  o_remainder
);

    localparam logic [pcg_pkg::CNT_W-1:0] CNT_LAST = pcg_pkg::CNT_W'(pcg_pkg::WORD_W - 1);

    logic [pcg_pkg::WORD_W-1:0] r_num, r_div, r_rem;
    logic [pcg_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_busy, r_done;
    logic [pcg_pkg::WORD_W:0]   n_part, n_diff;

    always_comb begin
        n_part = {r_rem, r_num[pcg_pkg::WORD_W-1]};
        n_diff = n_part - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (n_part >= {1'b0, r_div}) begin
                r_rem <= n_diff[pcg_pkg::WORD_W-1:0];
            end else begin
                r_rem <= n_part[pcg_pkg::WORD_W-1:0];
            end
            r_num <= {r_num[pcg_pkg::WORD_W-2:0], 1'b0};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_remainder   = r_rem;

endmodule

`default_nettype wire

/* design/pcg_random_generator_core.sv */
// pcg random generator, rxs-m-xs permutation over a 32-bit lcg state
// input channel s_axis: one request per number; tuser selects the mode
//   (raw word, word mod bound, or word - 2^31 as q0.31), tdata holds the bound
// output channel m_axis: tdata is the value, tuser[0] flags a zero bound in bounded mode
// i_cfg_we / i_cfg_wdata load the generator state with a seed; the user writes
// it idle only, which the block does not enforce; one request at a time: the
// lcg step and the permutation multiply both run on one shift-add multiplier
// at one bit per cycle, and the bounded mode with a nonzero bound adds a
// restoring remainder at one bit per cycle
// after accept the sequencer runs the lcg multiply, the permutation shift,
// the permutation multiply and, in bounded mode with a nonzero bound, the
// remainder; the input reopens as the result enters the output register
// a stalled receiver holds the result; a new request may then run up to the
// output stage and waits there until the held result is taken
// synchronous active-low reset: state zero, no result pending
`default_nettype none
`include "assert_macros.svh"

module pcg_random_generator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // seed write
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    // request channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] bound
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] value
    output logic [0:0]       m_axis_tuser    // [0] bound_error
);

    localparam int W = pcg_pkg::WORD_W;

    // sequencer codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LCG_MUL  = 3'd1;
    localparam logic [2:0] ST_PERM     = 3'd2;
    localparam logic [2:0] ST_PERM_MUL = 3'd3;
    localparam logic [2:0] ST_REM      = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0]   r_state, n_state;
    logic [W-1:0] r_gen, r_word, r_bound;
    logic [1:0]   r_mode;
    logic         r_m_valid;
    logic [W-1:0] r_m_value;
    logic         r_m_err;

    logic         w_accept, w_out_free;
    logic         w_mul_start, w_rem_start;
    logic [W-1:0] w_mul_a, w_mul_b, w_product, w_remainder;
    pcg_pkg::t_unit_status w_mul_st, w_rem_st;

    // permutation pieces
    logic [4:0]   w_sh;
    logic [W-1:0] w_rxs, w_xs;
    logic [W-1:0] w_value;
    logic         w_err;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // random shift by top nibble plus 4, then xor
    assign w_sh  = {1'b0, r_gen[W-1 -: 4]} + pcg_pkg::SHIFT_BIAS;
    assign w_rxs = (r_gen >> w_sh) ^ r_gen;
    // final xorshift on the permuted product
    assign w_xs  = (w_product >> pcg_pkg::XS_SHIFT) ^ w_product;

    // multiplier shared between the lcg step and the permutation
    assign w_mul_start = w_accept || (r_state == ST_PERM);
    assign w_mul_a     = (r_state == ST_PERM) ? w_rxs : r_gen;
    assign w_mul_b     = (r_state == ST_PERM) ? pcg_pkg::PERM_MUL : pcg_pkg::LCG_MUL;

    assign w_rem_start = (r_state == ST_PERM_MUL) && w_mul_st.done
                         && (r_mode == pcg_pkg::MODE_BOUNDED) && (r_bound != '0);

    pcg_mul_serial u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_status  (w_mul_st),
        .o_product (w_product)
    );

    pcg_rem_serial u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_rem_start),
        .i_dividend  (w_xs),
        .i_divisor   (r_bound),
        .o_status    (w_rem_st),
        .o_remainder (w_remainder)
    );

    // mode select on the finished word
    always_comb begin
        w_value = r_word;
        w_err   = 1'b0;
        case (r_mode)
            pcg_pkg::MODE_BOUNDED: begin
                if (r_bound == '0) begin
                    w_value = '0;
                    w_err   = 1'b1;
                end
            end
            pcg_pkg::MODE_SIGNED: begin
                w_value = {~r_word[W-1], r_word[W-2:0]};
            end
            default: begin
                w_value = r_word;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_LCG_MUL;
            end
            ST_LCG_MUL: begin
                if (w_mul_st.done) n_state = ST_PERM;
            end
            ST_PERM: begin
                n_state = ST_PERM_MUL;
            end
            ST_PERM_MUL: begin
                if (w_mul_st.done) n_state = w_rem_start ? ST_REM : ST_DONE;
            end
            ST_REM: begin
                if (w_rem_st.done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_gen     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // seed write loads state; user writes only while idle, unchecked
            if (i_cfg_we) begin
                r_gen <= i_cfg_wdata;
            end else if ((r_state == ST_LCG_MUL) && w_mul_st.done) begin
                r_gen <= w_product + pcg_pkg::LCG_INC;
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= s_axis_tuser;
            r_bound <= s_axis_tdata;
        end
        if ((r_state == ST_PERM_MUL) && w_mul_st.done) begin
            r_word <= w_xs;
        end else if ((r_state == ST_REM) && w_rem_st.done) begin
            r_word <= w_remainder;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_m_value <= w_value;
            r_m_err   <= w_err;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_value;
    assign m_axis_tuser[0] = r_m_err;

    // a taken request keeps the input closed on the next cycle
    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, w_accept, !s_axis_tready,
        "request accepted but input still ready")
    // the shared multiplier and the remainder never run together
    `ASSERT_ALWAYS(a_units_exclusive, i_clk, i_rst_n, !(w_mul_st.busy && w_rem_st.busy),
        "multiplier and remainder busy at once")
    // a flagged zero bound always carries a zero value
    `ASSERT_ALWAYS(a_err_zero_value, i_clk, i_rst_n,
        !(r_m_valid && r_m_err) || (r_m_value == '0),
        "bound error with nonzero value")

endmodule

`default_nettype wire

/* bench/pcg_result_checker.sv */
`timescale 1ns / 100ps

module pcg_result_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_req_bound,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [31:0] i_res_value,
    input  wire logic        i_res_error,
    output int               o_pending,
    output int               o_fail_count
);

    typedef struct packed {
        logic [31:0] value;
        logic        bound_error;
    } t_pcg_result;

    logic [31:0] pred_state;
    t_pcg_result expected_q[$];
    int          fail_total;
    int          result_idx;

    initial begin
        fail_total   = 0;
        result_idx   = 0;
        pred_state   = '0;
    end

    function automatic logic [31:0] lcg_next(input logic [31:0] cur);
        return cur * pcg_pkg::LCG_MUL + pcg_pkg::LCG_INC;
    endfunction

    // rxs-m-xs output permutation
    function automatic logic [31:0] rxs_m_xs(input logic [31:0] s);
        logic [4:0]  sh;
        logic [31:0] w;
        sh = 5'(s >> pcg_pkg::SEL_SHIFT) + pcg_pkg::SHIFT_BIAS;
        w  = ((s >> sh) ^ s) * pcg_pkg::PERM_MUL;
        w  = (w >> pcg_pkg::XS_SHIFT) ^ w;
        return w;
    endfunction

    function automatic t_pcg_result shape_number(input logic [31:0] word,
                                                 input logic [1:0] mode,
                                                 input logic [31:0] bnd);
        t_pcg_result r;
        r.bound_error = 1'b0;
        case (mode)
            pcg_pkg::MODE_BOUNDED: begin
                if (bnd == '0) begin
                    r.value       = '0;
                    r.bound_error = 1'b1;
                end else begin
                    r.value = word % bnd;
                end
            end
            pcg_pkg::MODE_SIGNED: r.value = word ^ 32'h8000_0000;
            default:              r.value = word;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pcg_result want;
        t_pcg_result got;
        if (!i_rst_n) begin
            pred_state = '0;
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we)
                pred_state = i_cfg_wdata;
            if (i_req_valid && i_req_ready) begin
                pred_state = lcg_next(pred_state);
                expected_q.push_back(shape_number(rxs_m_xs(pred_state), i_req_type,
                                                  i_req_bound));
            end
            if (i_res_valid && i_res_ready) begin
                got.value       = i_res_value;
                got.bound_error = i_res_error;
                if (expected_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("result %0d: none expected, got value %h err %b",
                                 result_idx, got.value, got.bound_error);
                end else begin
                    want = expected_q.pop_front();
                    if (got.value !== want.value || got.bound_error !== want.bound_error) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("result %0d: expected value %h err %b, got value %h err %b",
                                     result_idx, want.value, want.bound_error,
                                     got.value, got.bound_error);
                    end
                end
                result_idx++;
            end
            o_pending <= expected_q.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

/* bench/tb_pcg_random_generator_core.sv */
`timescale 1ns / 100ps

module tb_pcg_random_generator_core;

    // the fourth mode code has no name in the package; it acts as raw
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 120;   // above the longest accept-to-result latency

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [31:0] bound
    logic [1:0]  s_axis_tuser;    // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [31:0] value
    logic [0:0]  m_axis_tuser;    // [0] bound_error

    int pending;
    int fail_count;
    bit quiet_tail = 1'b0;        // no idling on either side once set

    logic [31:0] phase_seed [PHASES] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                                         32'h0000_0001, 32'h0, 32'h0};

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    pcg_random_generator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // watches both channels and the seed port, predicts every number
    pcg_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_req_bound  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_value  (m_axis_tdata),
        .i_res_error  (m_axis_tuser[0]),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // one request; an idle burst may come first, tvalid stays high otherwise
    task automatic send_request(input logic [1:0] mode, input logic [31:0] bnd);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= bnd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending and wait for every outstanding number
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);                 // let the last accepted request be counted
        while (pending != 0) @(posedge i_clk);
    endtask

    // the seed is only written with the block idle
    task automatic load_seed(input logic [31:0] seed);
        drain_results();
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= $urandom;
    endtask

    // bound mix: zero, small, powers of two, near-full, full random
    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return 32'($urandom_range(1, 16));
            3:       return 32'h1 << $urandom_range(0, 31);
            4:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // receiver: ready with random stall bursts
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= pcg_pkg::MODE_RAW;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: state zero from reset
        send_request(pcg_pkg::MODE_RAW,     32'h0000_0000);
        send_request(pcg_pkg::MODE_RAW,     32'hFFFF_FFFF);   // bound ignored in raw mode
        send_request(pcg_pkg::MODE_BOUNDED, 32'h0000_0000);   // zero bound raises the error flag
        send_request(pcg_pkg::MODE_BOUNDED, 32'h0000_0001);
        send_request(pcg_pkg::MODE_BOUNDED, 32'hFFFF_FFFF);
        send_request(pcg_pkg::MODE_BOUNDED, 32'h8000_0000);
        send_request(pcg_pkg::MODE_BOUNDED, 32'h0000_0007);
        send_request(pcg_pkg::MODE_SIGNED,  32'h0000_0000);
        send_request(pcg_pkg::MODE_SIGNED,  32'hFFFF_FFFF);
        send_request(MODE_SPARE,            32'h0000_0005);   // unused mode behaves as raw
        send_request(MODE_SPARE,            32'hFFFF_FFFF);
        // directed: top seed
        load_seed(32'hFFFF_FFFF);
        send_request(pcg_pkg::MODE_RAW,     32'h0000_0000);
        send_request(pcg_pkg::MODE_BOUNDED, 32'h0000_0000);
        send_request(pcg_pkg::MODE_BOUNDED, 32'h0000_0002);
        send_request(pcg_pkg::MODE_SIGNED,  32'h1234_5678);
        send_request(MODE_SPARE,            32'h0000_0000);
        // directed: seed zero written explicitly
        load_seed(32'h0000_0000);
        send_request(pcg_pkg::MODE_RAW,     32'h0000_0000);
        send_request(pcg_pkg::MODE_BOUNDED, 32'h0000_0003);
        send_request(pcg_pkg::MODE_SIGNED,  32'h0000_0000);

        // random phases, each from its own seed
        phase_seed[4] = $urandom;
        phase_seed[5] = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            load_seed(phase_seed[p]);
            if (p == PHASES - 1)
                quiet_tail = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == PHASE_ITEMS / 2)
                    drain_results();           // sender holds off until all numbers are back
                send_request(2'($urandom_range(0, 3)), pick_bound());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog, far above the slowest correct run
    initial begin
        #(50_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule

/* pcg_random_generator_core.f */
+incdir+design
design/pcg_pkg.sv
design/pcg_mul_serial.sv
design/pcg_rem_serial.sv
design/pcg_random_generator_core.sv
bench/pcg_result_checker.sv
bench/tb_pcg_random_generator_core.sv
